// ===== rtl/bhq_pkg.sv =====
// bhq_pkg: sizes, codes, payload structs and cell handoff types of the binary max-heap queue
// used by bhq_cell and binary_max_heap_queue; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

package bhq_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 32;

  // heap levels including the root; node indices are 1-based
  localparam int NUM_LVL  = $clog2(CAPACITY + 1);
  localparam int NODE_W   = NUM_LVL;
  localparam int PATH_W   = NUM_LVL - 1;
  localparam int LEFT_W   = $clog2(NUM_LVL);

  localparam int ITEM_KEY_W = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 11;

  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SIFT   = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [ITEM_KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [ITEM_KEY_W-1:0] top_key;
    logic [STATUS_W-1:0]   status;
    logic [COUNT_W-1:0]    entry_count;
  } out_item_t;

  // work handed from one level cell to the next
  typedef struct packed {
    logic              valid;
    logic              op;
    logic [KEY_W-1:0]  key;
    logic [NODE_W-1:0] node;
    logic [PATH_W-1:0] path;
    logic [LEFT_W-1:0] left;
  } tok_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] node;
    logic [KEY_W-1:0]  key;
  } wr_t;

  typedef struct packed {
    logic [NODE_W-1:0] rd_node;
    wr_t               wr;
  } ram_req_t;

  // entries of one level that sit in the even (bank 0) or odd (bank 1) index bank
  function automatic int bank_depth(input int lvl, input int bank);
    int lo;
    int hi;
    lo = 1 << lvl;
    hi = (2 * lo - 1 < CAPACITY) ? 2 * lo - 1 : CAPACITY;
    if (bank == 1) begin
      return (hi + 1) / 2 - lo / 2;
    end
    return hi / 2 - (lo - 1) / 2;
  endfunction

  // level of a 1-based node index
  function automatic logic [LEFT_W-1:0] msb_pos(input logic [NODE_W-1:0] v);
    logic [LEFT_W-1:0] p;
    p = '0;
    for (int i = 0; i < NODE_W; i++) begin
      if (v[i]) begin
        p = LEFT_W'(i);
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bhq_ram.sv =====
// bhq_ram: generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/bhq_cell.sv =====
// bhq_cell: one heap level; compares the carried key against the row read from its level
// and hands the walk to the level below; uses bhq_pkg
`timescale 1ns / 1ps
`default_nettype none

module bhq_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  bhq_pkg::tok_t                    tok_in,
  input  logic [bhq_pkg::NODE_W-1:0]       fetch_node,
  input  logic [bhq_pkg::NODE_W-1:0]       heap_cnt,
  input  bhq_pkg::wr_t                     wb_in,
  input  logic [bhq_pkg::KEY_W-1:0]        rd_even,
  input  logic [bhq_pkg::KEY_W-1:0]        rd_odd,
  output bhq_pkg::ram_req_t                req,
  output bhq_pkg::tok_t                    tok_out,
  output bhq_pkg::wr_t                     wb_out,
  output logic                             done
);

  localparam int NW = bhq_pkg::NODE_W;
  localparam int PW = bhq_pkg::PATH_W;
  localparam int KW = bhq_pkg::KEY_W;
  localparam int LW = bhq_pkg::LEFT_W;

  bhq_pkg::tok_t cur;
  bhq_pkg::wr_t  own_wr;

  logic [KW-1:0] slot_key;
  logic [KW-1:0] best_key;
  logic [KW-1:0] child_key;
  logic          l_ok;
  logic          r_ok;
  logic          pick_l;
  logic          pick_r;
  logic          ins_swap;
  logic [NW-1:0] child;
  logic [NW-1:0] parent;
  logic [NW:0]   grand;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else begin
      cur <= tok_in;
    end
  end

  // the row is read in the cycle the token arrives, data is back for the compute cycle
  assign req.rd_node = tok_in.valid ? tok_in.node : fetch_node;
  assign req.wr      = wb_in.en ? wb_in : own_wr;

  always_comb begin
    slot_key  = cur.node[0] ? rd_odd : rd_even;
    ins_swap  = cur.key > slot_key;
    // sift: cur.node is the left child of the hole
    l_ok      = cur.node <= heap_cnt;
    r_ok      = (cur.node | NW'(1)) <= heap_cnt;
    pick_l    = l_ok && (rd_even > cur.key);
    best_key  = pick_l ? rd_even : cur.key;
    pick_r    = r_ok && (rd_odd > best_key);
    child     = pick_r ? (cur.node | NW'(1)) : cur.node;
    child_key = pick_r ? rd_odd : rd_even;
    grand     = {child, 1'b0};
    parent    = cur.node >> 1;

    tok_out = '0;
    wb_out  = '0;
    own_wr  = '0;
    done    = 1'b0;

    if (cur.valid) begin
      unique case (cur.op)
        bhq_pkg::OP_INSERT: begin
          if (cur.left == '0) begin
            own_wr.en   = 1'b1;
            own_wr.node = cur.node;
            own_wr.key  = cur.key;
            done        = 1'b1;
          end else begin
            if (ins_swap) begin
              own_wr.en   = 1'b1;
              own_wr.node = cur.node;
              own_wr.key  = cur.key;
            end
            tok_out.valid = 1'b1;
            tok_out.op    = bhq_pkg::OP_INSERT;
            tok_out.key   = ins_swap ? slot_key : cur.key;
            tok_out.node  = {cur.node[NW-2:0], cur.path[PW-1]};
            tok_out.path  = cur.path << 1;
            tok_out.left  = cur.left - LW'(1);
          end
        end
        bhq_pkg::OP_SIFT: begin
          wb_out.en   = 1'b1;
          wb_out.node = parent;
          if (!pick_l && !pick_r) begin
            wb_out.key = cur.key;
            done       = 1'b1;
          end else begin
            wb_out.key = child_key;
            if (grand > {1'b0, heap_cnt}) begin
              // promoted child is a leaf: the carried key settles there
              own_wr.en   = 1'b1;
              own_wr.node = child;
              own_wr.key  = cur.key;
              done        = 1'b1;
            end else begin
              tok_out.valid = 1'b1;
              tok_out.op    = bhq_pkg::OP_SIFT;
              tok_out.key   = cur.key;
              tok_out.node  = grand[NW-1:0];
            end
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/binary_max_heap_queue.sv =====
// Binary max-heap priority queue of unsigned keys. An item with kind 0 inserts its key (status
// full if the heap already holds CAPACITY keys), kind 1 removes and returns the largest key
// (status empty on an empty heap); every result carries the count after the operation. The
// heap is a chain of level cells, one per level below the root, each with its own two memory
// banks (even and odd node indices), so a parent's two children come out in one read; the root
// sits in a register. Insert walks from the root down the path to the new slot, keeping the
// larger key at each level; extract first fetches the last key, then sifts it down from the
// root. The walk moves one level per clock. Empty, full, first-insert and last-extract cases
// go straight to the result without a walk. One item is in work at a time; a new item is
// taken while the previous result still waits on the output register.
// Uses bhq_pkg, bhq_cell and bhq_ram.
`timescale 1ns / 1ps
`default_nettype none

module binary_max_heap_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  bhq_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output bhq_pkg::out_item_t result
);

  localparam int NL  = bhq_pkg::NUM_LVL;
  localparam int NW  = bhq_pkg::NODE_W;
  localparam int PW  = bhq_pkg::PATH_W;
  localparam int LW  = bhq_pkg::LEFT_W;
  localparam int KW  = bhq_pkg::KEY_W;
  localparam int IKW = bhq_pkg::ITEM_KEY_W;
  localparam int CW  = bhq_pkg::COUNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_LAST  = 3'd3;
  localparam logic [2:0] S_RUN   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]                    state;
  logic [NW-1:0]                 cnt;
  logic [NW-1:0]                 pos;
  logic [KW-1:0]                 root;
  logic [KW-1:0]                 key_reg;
  logic [IKW-1:0]                fin_top;
  logic [bhq_pkg::STATUS_W-1:0]  fin_status;

  logic                          accept;
  logic                          post;
  logic [LW-1:0]                 pos_lvl;
  logic [LW-1:0]                 sh_amt;
  logic [2*NW-1:0]               shifted;
  logic [KW-1:0]                 last_key;
  logic                          run_done;
  bhq_pkg::tok_t                 launch;

  bhq_pkg::tok_t     tok     [1:NL];
  bhq_pkg::wr_t      wb      [1:NL];
  bhq_pkg::ram_req_t req     [1:NL-1];
  logic [KW-1:0]     rdata   [1:NL-1][2];
  logic [NL-2:0]     done_vec;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign post       = (state == S_FIN) && (!result_valid || !result_stall);
  assign run_done   = |done_vec;

  assign pos_lvl = bhq_pkg::msb_pos(pos);
  assign sh_amt  = LW'(PW) - pos_lvl;
  // path bits below the leading one, next branch at the top
  assign shifted = {{NW{1'b0}}, pos} << sh_amt;

  always_comb begin
    last_key = '0;
    for (int i = 1; i < NL; i++) begin
      if (pos_lvl == LW'(i)) begin
        last_key = rdata[i][pos[0]];
      end
    end
  end

  always_comb begin
    launch = '0;
    if (state == S_INS) begin
      launch.valid = 1'b1;
      launch.op    = bhq_pkg::OP_INSERT;
      launch.key   = (key_reg > root) ? root : key_reg;
      launch.node  = NW'({1'b1, shifted[PW-1]});
      launch.path  = shifted[PW-1:0] << 1;
      launch.left  = pos_lvl - LW'(1);
    end else if ((state == S_LAST) && (cnt != NW'(1))) begin
      launch.valid = 1'b1;
      launch.op    = bhq_pkg::OP_SIFT;
      launch.key   = last_key;
      launch.node  = NW'(2);
    end
  end

  assign tok[1]  = launch;
  assign wb[NL]  = '0;

  for (genvar g = 1; g < NL; g++) begin : g_lvl
    bhq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .tok_in     (tok[g]),
      .fetch_node (pos),
      .heap_cnt   (cnt),
      .wb_in      (wb[g+1]),
      .rd_even    (rdata[g][0]),
      .rd_odd     (rdata[g][1]),
      .req        (req[g]),
      .tok_out    (tok[g+1]),
      .wb_out     (wb[g]),
      .done       (done_vec[g-1])
    );

    for (genvar b = 0; b < 2; b++) begin : g_bank
      localparam int D  = bhq_pkg::bank_depth(g, b);
      localparam int AW = (D > 1) ? $clog2(D) : 1;
      if (D > 0) begin : g_mem
        logic [AW-1:0] raddr;
        logic [AW-1:0] waddr;
        if (g >= 2) begin : g_deep
          assign raddr = req[g].rd_node[AW:1];
          assign waddr = req[g].wr.node[AW:1];
        end else begin : g_first
          assign raddr = '0;
          assign waddr = '0;
        end
        bhq_ram #(
          .WIDTH (KW),
          .DEPTH (D)
        ) u_ram (
          .clk   (clk),
          .we    (req[g].wr.en && (req[g].wr.node[0] == 1'(b))),
          .waddr (waddr),
          .wdata (req[g].wr.key),
          .raddr (raddr),
          .rdata (rdata[g][b])
        );
      end else begin : g_none
        assign rdata[g][b] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (post) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.kind == bhq_pkg::KIND_INSERT) begin
              fin_top <= '0;
              if (cnt == NW'(bhq_pkg::CAPACITY)) begin
                fin_status <= bhq_pkg::ST_FULL;
                state      <= S_FIN;
              end else begin
                fin_status <= bhq_pkg::ST_OK;
                cnt        <= cnt + NW'(1);
                pos        <= cnt + NW'(1);
                key_reg    <= KW'(item.key);
                if (cnt == '0) begin
                  root  <= KW'(item.key);
                  state <= S_FIN;
                end else begin
                  state <= S_INS;
                end
              end
            end else begin
              if (cnt == '0) begin
                fin_top    <= '0;
                fin_status <= bhq_pkg::ST_EMPTY;
                state      <= S_FIN;
              end else begin
                fin_top    <= IKW'(root);
                fin_status <= bhq_pkg::ST_OK;
                cnt        <= cnt - NW'(1);
                pos        <= cnt;
                state      <= (cnt == NW'(1)) ? S_FIN : S_FETCH;
              end
            end
          end
        end
        S_INS: begin
          if (key_reg > root) begin
            root <= key_reg;
          end
          state <= S_RUN;
        end
        S_FETCH: begin
          state <= S_LAST;
        end
        S_LAST: begin
          if (cnt == NW'(1)) begin
            root  <= last_key;
            state <= S_FIN;
          end else begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (run_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (post) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // the first level hands the promoted key up into the root
      if (wb[1].en) begin
        root <= wb[1].key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      result.top_key     <= fin_top;
      result.status      <= fin_status;
      result.entry_count <= CW'(cnt);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_token_past_bottom: assert property (@(posedge clk) disable iff (rst)
    !tok[NL].valid)
    else $error("walk left the deepest level");

  a_done_only_in_run: assert property (@(posedge clk) disable iff (rst)
    run_done |-> (state == S_RUN))
    else $error("level cell finished outside of a walk");

  a_one_cell_done: assert property (@(posedge clk) disable iff (rst)
    $onehot0(done_vec))
    else $error("more than one level cell finished at once");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= NW'(bhq_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_FIN)
    else $error("result posted without a finished item");
`endif

endmodule

`default_nettype wire
